// ===== design/cmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // field widths
    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int OUT_W   = 13;
    localparam int WID_W   = 13;
    localparam int COLOR_W = 24;
    localparam int THR_W   = 18;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int SUM_W   = 37;
    localparam int CNT_W   = 25;
    localparam int MARKERS = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd3;

    localparam logic [WID_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [COLOR_W-1:0] RST_FIRST_COLOR  = 24'hED1C24;
    localparam logic [COLOR_W-1:0] RST_SECOND_COLOR = 24'h22B14C;
    localparam logic [THR_W-1:0]   RST_THRESHOLD    = 18'd300;

    // frame queue between front and back; depth must be a power of two
    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = $clog2(QDEPTH + 1);

    localparam logic [OUT_W-1:0] COORD_NONE = {OUT_W{1'b1}};

    typedef struct packed {
        logic [MARKERS-1:0][SUM_W-1:0] sum_x;
        logic [MARKERS-1:0][SUM_W-1:0] sum_y;
        logic [MARKERS-1:0][CNT_W-1:0] count;
    } t_frame_sums;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    typedef logic [2:0][SQ_W-1:0] t_sq3;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic signed [PIX_W:0]     d;
        logic signed [2*PIX_W+1:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/cmc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [cmc_pkg::PIX_W-1:0]      i_red,
    input  wire logic [cmc_pkg::PIX_W-1:0]      i_green,
    input  wire logic [cmc_pkg::PIX_W-1:0]      i_blue,
    input  wire logic                          i_last_pixel,
    input  wire logic [cmc_pkg::Q_CW-1:0]       i_q_count,
    output logic                               o_push,
    output cmc_pkg::t_frame_sums               o_sums
);
    import cmc_pkg::*;

    logic [WID_W-1:0]   r_image_width;
    logic [COLOR_W-1:0] r_color [MARKERS];
    logic [THR_W-1:0]   r_threshold;

    logic [POS_W-1:0] r_col, r_row;

    logic               r_s1_vld, r_s1_last;
    logic [POS_W-1:0]   r_s1_x, r_s1_y;
    t_sq3               r_s1_sq [MARKERS];

    logic               r_s2_vld, r_s2_last;
    logic [POS_W-1:0]   r_s2_x, r_s2_y;
    logic [MARKERS-1:0] r_s2_hit;

    t_frame_sums r_acc, n_acc;

    logic             accept;
    logic [WID_W-1:0] next_col;
    logic [Q_CW:0]    pending;

    // frames already queued plus end-of-frame beats still in the pipe
    assign pending = {1'b0, i_q_count} + (Q_CW+1)'(r_s1_vld & r_s1_last)
                   + (Q_CW+1)'(r_s2_vld & r_s2_last);
    assign o_stall = pending >= (Q_CW+1)'(QDEPTH);
    assign accept  = i_valid & ~o_stall;
    assign next_col = {1'b0, r_col} + WID_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= RST_IMAGE_WIDTH;
            r_color[0]    <= RST_FIRST_COLOR;
            r_color[1]    <= RST_SECOND_COLOR;
            r_threshold   <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width <= i_cfg_data[WID_W-1:0];
                CFG_FIRST_COLOR:  r_color[0]    <= i_cfg_data[COLOR_W-1:0];
                CFG_SECOND_COLOR: r_color[1]    <= i_cfg_data[COLOR_W-1:0];
                CFG_THRESHOLD:    r_threshold   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (i_last_pixel) begin
                r_col <= '0;
                r_row <= '0;
            end else if (next_col >= r_image_width || next_col >= WID_W'(MAX_WIDTH)) begin
                r_col <= '0;
                if (r_row == POS_W'(MAX_HEIGHT - 1)) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + POS_W'(1);
                end
            end else begin
                r_col <= next_col[POS_W-1:0];
            end
        end
    end

    // stage 1: squared channel differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_last_pixel;
            r_s1_x    <= r_col;
            r_s1_y    <= r_row;
            for (int m = 0; m < MARKERS; m++) begin
                r_s1_sq[m][0] <= sq_diff(i_red,   r_color[m][23:16]);
                r_s1_sq[m][1] <= sq_diff(i_green, r_color[m][15:8]);
                r_s1_sq[m][2] <= sq_diff(i_blue,  r_color[m][7:0]);
            end
        end
    end

    // stage 2: distance against threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_last <= r_s1_last;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            for (int m = 0; m < MARKERS; m++) begin
                r_s2_hit[m] <= (DIST_W'(r_s1_sq[m][0]) + DIST_W'(r_s1_sq[m][1])
                              + DIST_W'(r_s1_sq[m][2])) <= r_threshold;
            end
        end
    end

    // stage 3: accumulate; hand the finished frame to the queue
    always_comb begin
        n_acc = r_acc;
        for (int m = 0; m < MARKERS; m++) begin
            if (r_s2_hit[m]) begin
                n_acc.sum_x[m] = r_acc.sum_x[m] + SUM_W'(r_s2_x);
                n_acc.sum_y[m] = r_acc.sum_y[m] + SUM_W'(r_s2_y);
                n_acc.count[m] = r_acc.count[m] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_last) begin
                r_acc <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_push = r_s2_vld & r_s2_last;
    assign o_sums = n_acc;

endmodule

`default_nettype wire

// ===== design/cmc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmc_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  cmc_pkg::t_frame_sums         i_data,
    input  wire logic                    i_pop,
    output cmc_pkg::t_frame_sums         o_head,
    output logic                         o_not_empty,
    output logic [cmc_pkg::Q_CW-1:0]     o_count
);
    import cmc_pkg::*;

    t_frame_sums      r_mem [QDEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_CW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers wrap by overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head      = r_mem[r_rp];
    assign o_not_empty = r_count != '0;
    assign o_count     = r_count;

endmodule

`default_nettype wire

// ===== design/cmc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmc_divider (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  cmc_pkg::t_div_req  i_req,
    output cmc_pkg::t_div_rsp  o_rsp
);
    import cmc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               r_busy, r_done;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_rem, r_dvs;
    logic [CNT_W:0]     rem_sh;
    logic               fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            if (fits) begin
                r_rem <= CNT_W'(rem_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/cmc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  cmc_pkg::t_frame_sums           i_head,
    input  wire logic                      i_not_empty,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_first_found,
    output logic signed [cmc_pkg::OUT_W-1:0] o_first_x,
    output logic signed [cmc_pkg::OUT_W-1:0] o_first_y,
    output logic                           o_second_found,
    output logic signed [cmc_pkg::OUT_W-1:0] o_second_x,
    output logic signed [cmc_pkg::OUT_W-1:0] o_second_y
);
    import cmc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       r_sel;      // [1] marker, [0] 0 = x, 1 = y
    logic [OUT_W-1:0] r_res [4];
    logic             r_valid;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     load;
    logic     found0, found1;

    always_comb begin
        div_req.start    = r_state == ST_START;
        div_req.dividend = r_sel[0] ? i_head.sum_y[r_sel[1]] : i_head.sum_x[r_sel[1]];
        div_req.divisor  = i_head.count[r_sel[1]];
    end

    cmc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign load   = (r_state == ST_OUT) && (!r_valid || !i_stall);
    assign o_pop  = load;
    assign found0 = i_head.count[0] != '0;
    assign found1 = i_head.count[1] != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_not_empty) begin
                        r_sel   <= '0;
                        r_state <= ST_START;
                    end
                end
                ST_START: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_sel == 2'd3) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_sel   <= r_sel + 2'd1;
                            r_state <= ST_START;
                        end
                    end
                end
                ST_OUT: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT && div_rsp.done) begin
            r_res[r_sel] <= div_rsp.quotient[OUT_W-1:0];
        end
    end

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_first_found  <= found0;
            o_first_x      <= found0 ? r_res[0] : COORD_NONE;
            o_first_y      <= found0 ? r_res[1] : COORD_NONE;
            o_second_found <= found1;
            o_second_x     <= found1 ? r_res[2] : COORD_NONE;
            o_second_y     <= found1 ? r_res[3] : COORD_NONE;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== design/color_marker_centroid.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   valid         stall          payload
// ------    -----------   ------------   --------------------------------------------
// pixel     i_in_valid    o_in_stall     i_red, i_green, i_blue, i_last_pixel
// result    o_out_valid   i_out_stall    o_first_found/x/y, o_second_found/x/y
// config    i_cfg_we      -              i_cfg_index, i_cfg_data
//
// Pixels are taken one per cycle while o_in_stall is low; each passes a three-stage match
// and accumulate pipe. After the last pixel of a frame, its four centroid quotients run one
// after another through a single bit-serial divider before the result appears.
// Two finished frames can wait for the divider; the pixel side stalls only when both
// slots are spoken for. Reset restores the default registers and clears all sums.
module color_marker_centroid (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [cmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [cmc_pkg::PIX_W-1:0]           i_red,
    input  wire logic [cmc_pkg::PIX_W-1:0]           i_green,
    input  wire logic [cmc_pkg::PIX_W-1:0]           i_blue,
    input  wire logic                               i_last_pixel,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_first_found,
    output logic signed [cmc_pkg::OUT_W-1:0]         o_first_x,
    output logic signed [cmc_pkg::OUT_W-1:0]         o_first_y,
    output logic                                    o_second_found,
    output logic signed [cmc_pkg::OUT_W-1:0]         o_second_x,
    output logic signed [cmc_pkg::OUT_W-1:0]         o_second_y
);
    import cmc_pkg::*;

    logic            push, pop, not_empty;
    t_frame_sums     push_data, head;
    logic [Q_CW-1:0] q_count;

    cmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .i_q_count    (q_count),
        .o_push       (push),
        .o_sums       (push_data)
    );

    cmc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_count     (q_count)
    );

    cmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_not_empty    (not_empty),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_first_found  (o_first_found),
        .o_first_x      (o_first_x),
        .o_first_y      (o_first_y),
        .o_second_found (o_second_found),
        .o_second_x     (o_second_x),
        .o_second_y     (o_second_y)
    );

endmodule

`default_nettype wire
